@@ rtl/core/shlj_pkg.sv @@
// shared constants, register indexes and saturating helpers for the shifted
// lennard-jones pair force block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package shlj_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 47;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REP0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATT0 = 3'd2;
  localparam int COEF_STRIDE = 2;

  localparam logic [5:0] WORD_LAST = 6'd63;
  localparam logic [5:0] ROOT_LAST = 6'd32;

  localparam logic signed [47:0] POS48 = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] NEG48 = 48'sh8000_0000_0000;
  localparam logic signed [63:0] POS64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] NEG64 = 64'sh8000_0000_0000_0000;

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  // gas force on one axis from a q32.32 product, saturated to 48 bits
  function automatic logic signed [47:0] axis_force(input logic [63:0] p,
                                                    input logic fneg,
                                                    input logic dneg);
    logic [55:0] f;
    logic gas_neg;
    f = p[63:8];
    gas_neg = !(fneg ^ dneg);
    if (gas_neg) begin
      if (f >= 56'h80_0000_0000_00) axis_force = NEG48;
      else axis_force = -$signed(f[47:0]);
    end else begin
      if (f > 56'(POS48)) axis_force = POS48;
      else axis_force = $signed(f[47:0]);
    end
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? NEG64 : POS64;
    sat_add64 = s;
  endfunction

  function automatic logic signed [47:0] clamp48(input logic signed [63:0] v);
    if (v > 64'(POS48)) clamp48 = POS48;
    else if (v < 64'(NEG48)) clamp48 = NEG48;
    else clamp48 = v[47:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/shifted_lj_pair_force.sv @@
// shifted lennard-jones pair force engine, bit-serial datapath
// depends on shlj_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                          | dir | notes
// in      | in_valid/in_ready, in_*        | in  | one ion-gas pair per beat
// out     | out_valid/out_ready, out_*     | out | one result beat per pair
// cfg     | cfg_valid/cfg_ready, index/data| in  | always ready, index 0..4
//
// one shared shift-add multiplier, restoring divider and square-root
// recurrence, each retiring one bit (two radicand bits for the root) per cycle
// a normal pair runs 3 squares, 1 root, 2 divides, 9 multiplies; a zero
// distance pair ends after the squares and the root, with no divide or multiply
// the output register holds a finished beat while the next pair is computed;
// a pair ending while that beat is still unread waits in its output step
// synchronous active-low reset clears control, config and the ion sums

module shifted_lj_pair_force
  import shlj_pkg::*;
#(
  parameter int GAS_TYPES = 2
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire signed [31:0]          in_ion_x,
  input  wire signed [31:0]          in_ion_y,
  input  wire signed [31:0]          in_ion_z,
  input  wire signed [31:0]          in_gas_x,
  input  wire signed [31:0]          in_gas_y,
  input  wire signed [31:0]          in_gas_z,
  input  wire                        in_gas_type,
  input  wire                        in_last_pair,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic signed [47:0]         out_gas_force_x,
  output logic signed [47:0]         out_gas_force_y,
  output logic signed [47:0]         out_gas_force_z,
  output logic signed [47:0]         out_ion_total_x,
  output logic signed [47:0]         out_ion_total_y,
  output logic signed [47:0]         out_ion_total_z,
  output logic                       out_ion_total_valid,
  output logic                       out_bad_distance,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [CFG_IDX_W-1:0]        cfg_index,
  input  wire [CFG_DATA_W-1:0]       cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_SQRT, ST_POST, ST_OUT} state_t;
  typedef enum logic [3:0] {
    SP_SQX, SP_SQY, SP_SQZ, SP_ROOT, SP_INV, SP_I2, SP_I4, SP_I6,
    SP_REP, SP_LJ, SP_RS, SP_FP, SP_FX, SP_FY, SP_FZ
  } step_t;
  typedef enum logic [2:0] {GO_NONE, GO_MUL, GO_DIV, GO_SQRT, GO_OUT} go_t;

  state_t state_r;
  step_t  step_r;
  logic [5:0] cnt_r, cnt_last_r;

  // shared unit registers: acc holds product / remainder:dividend / radicand
  logic [127:0] acc_r;
  logic [63:0]  opa_r, opb_r;
  logic         div_sat_r;

  // pair registers
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic        type_r, lastp_r;
  logic [65:0] sum_r;
  logic [32:0] root_r;
  logic [48:0] m_r;
  logic        s_neg_r, bad_r, fneg_r;
  logic [63:0] i2_r, i6_r, fp_r;
  logic signed [47:0] fx_r, fy_r, fz_r;
  logic signed [63:0] ion_x_r, ion_y_r, ion_z_r;

  // config
  logic [30:0] shift_r;
  logic [46:0] rep_r [GAS_TYPES];
  logic [46:0] att_r [GAS_TYPES];

  // output register
  logic        out_valid_r;
  logic signed [47:0] ogx_r, ogy_r, ogz_r, oix_r, oiy_r, oiz_r;
  logic        oiv_r, obad_r;

  // multiplier step: add multiplicand on lsb of multiplier, shift right
  logic [64:0] mul_add;
  logic [63:0] mres, dres;
  assign mul_add = {1'b0, acc_r[127:64]} + (opb_r[0] ? {1'b0, opa_r} : 65'd0);
  assign mres = (|acc_r[127:96]) ? '1 : acc_r[95:32];

  // divider step
  logic [63:0] div_sh, div_rem;
  logic        div_ge;
  assign div_sh  = {acc_r[126:64], acc_r[63]};
  assign div_ge  = acc_r[127] || (div_sh >= opa_r);
  assign div_rem = div_ge ? div_sh - opa_r : div_sh;
  assign dres    = div_sat_r ? '1 : opb_r;

  // square root recurrence, two radicand bits per cycle
  logic [36:0] sq_rem2, sq_trial, sq_new;
  logic        sq_ge;
  assign sq_rem2  = {opa_r[34:0], acc_r[65:64]};
  assign sq_trial = {2'b00, opb_r[32:0], 2'b01};
  assign sq_ge    = sq_rem2 >= sq_trial;
  assign sq_new   = sq_ge ? sq_rem2 - sq_trial : sq_rem2;

  // post-processing terms
  logic [65:0] sum_add;
  logic [32:0] root;
  logic signed [33:0] s_val;
  logic        s_neg, bad_val, diff_neg;
  logic [32:0] s_mag;
  logic [48:0] m_val;
  logic [46:0] rep_sel, att_sel;
  logic [63:0] bq, diff;

  assign sum_add = sum_r + {1'b0, acc_r[64:0]};
  assign root    = opb_r[32:0];
  assign s_val   = $signed({1'b0, root}) - $signed({3'b000, shift_r});
  assign s_neg   = s_val[33];
  assign s_mag   = s_neg ? 33'(-s_val) : 33'(s_val);
  assign m_val   = {s_mag, 16'd0};
  assign bad_val = (root == 33'd0) || (s_val == 34'sd0);

  // gas types past the configured count use the last one
  always_comb begin
    rep_sel = '0;
    att_sel = '0;
    for (int g = 0; g < GAS_TYPES; g++) begin
      if ((g == GAS_TYPES - 1) ? (int'(type_r) >= g) : (int'(type_r) == g)) begin
        rep_sel = rep_r[g];
        att_sel = att_r[g];
      end
    end
  end

  assign bq       = {9'd0, att_sel, 8'd0};
  assign diff_neg = mres < bq;
  assign diff     = diff_neg ? bq - mres : mres - bq;

  // what to launch next on the shared unit
  go_t   go;
  step_t go_step;
  logic [63:0] la, lb;

  always_comb begin
    go = GO_NONE;
    go_step = step_r;
    la = '0;
    lb = '0;
    if (state_r == ST_IDLE && in_valid) begin
      go = GO_MUL;
      go_step = SP_SQX;
      la = {31'd0, mag33(33'(in_ion_x) - 33'(in_gas_x))};
      lb = la;
    end else if (state_r == ST_POST) begin
      unique case (step_r)
        SP_SQX: begin
          go = GO_MUL; go_step = SP_SQY;
          la = {31'd0, mag33(dy_r)}; lb = la;
        end
        SP_SQY: begin
          go = GO_MUL; go_step = SP_SQZ;
          la = {31'd0, mag33(dz_r)}; lb = la;
        end
        SP_SQZ: begin
          go = GO_SQRT; go_step = SP_ROOT;
        end
        SP_ROOT: begin
          if (bad_val) begin
            go = GO_OUT;
          end else begin
            go = GO_DIV; go_step = SP_INV;
            la = 64'h1_0000_0000; lb = {15'd0, m_val};
          end
        end
        SP_INV: begin
          go = GO_MUL; go_step = SP_I2; la = dres; lb = dres;
        end
        SP_I2: begin
          go = GO_MUL; go_step = SP_I4; la = mres; lb = mres;
        end
        SP_I4: begin
          go = GO_MUL; go_step = SP_I6; la = mres; lb = i2_r;
        end
        SP_I6: begin
          go = GO_MUL; go_step = SP_REP; la = {9'd0, rep_sel, 8'd0}; lb = mres;
        end
        SP_REP: begin
          go = GO_MUL; go_step = SP_LJ; la = i6_r; lb = diff;
        end
        SP_LJ: begin
          go = GO_MUL; go_step = SP_RS;
          la = {15'd0, root_r, 16'd0}; lb = {15'd0, m_r};
        end
        SP_RS: begin
          go = GO_DIV; go_step = SP_FP; la = i2_r; lb = mres;
        end
        SP_FP: begin
          go = GO_MUL; go_step = SP_FX; la = dres; lb = {15'd0, mag33(dx_r), 16'd0};
        end
        SP_FX: begin
          go = GO_MUL; go_step = SP_FY; la = fp_r; lb = {15'd0, mag33(dy_r), 16'd0};
        end
        SP_FY: begin
          go = GO_MUL; go_step = SP_FZ; la = fp_r; lb = {15'd0, mag33(dz_r), 16'd0};
        end
        SP_FZ: go = GO_OUT;
        default: go = GO_NONE;
      endcase
    end
  end

  // ion sums after this pair, skipped on a zero distance
  logic signed [63:0] ion_x_nxt, ion_y_nxt, ion_z_nxt;
  assign ion_x_nxt = bad_r ? ion_x_r : sat_add64(ion_x_r, -64'(fx_r));
  assign ion_y_nxt = bad_r ? ion_y_r : sat_add64(ion_y_r, -64'(fy_r));
  assign ion_z_nxt = bad_r ? ion_z_r : sat_add64(ion_z_r, -64'(fz_r));

  logic out_load;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= SP_SQX;
      cnt_r <= '0;
      cnt_last_r <= WORD_LAST;
      out_valid_r <= 1'b0;
      ion_x_r <= '0;
      ion_y_r <= '0;
      ion_z_r <= '0;
      shift_r <= '0;
      for (int g = 0; g < GAS_TYPES; g++) begin
        rep_r[g] <= '0;
        att_r[g] <= '0;
      end
    end else begin
      // configuration beats
      if (cfg_valid) begin
        if (cfg_index == REG_SHIFT) shift_r <= cfg_data[30:0];
        for (int g = 0; g < GAS_TYPES; g++) begin
          if (cfg_index == CFG_IDX_W'(int'(REG_REP0) + COEF_STRIDE * g)) rep_r[g] <= cfg_data;
          if (cfg_index == CFG_IDX_W'(int'(REG_ATT0) + COEF_STRIDE * g)) att_r[g] <= cfg_data;
        end
      end

      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      if (state_r == ST_IDLE && in_valid) begin
        dx_r <= 33'(in_ion_x) - 33'(in_gas_x);
        dy_r <= 33'(in_ion_y) - 33'(in_gas_y);
        dz_r <= 33'(in_ion_z) - 33'(in_gas_z);
        type_r <= in_gas_type;
        lastp_r <= in_last_pair;
        sum_r <= '0;
      end

      unique case (state_r)
        ST_MUL: begin
          acc_r <= {mul_add, acc_r[63:1]};
          opb_r <= {1'b0, opb_r[63:1]};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == cnt_last_r) state_r <= ST_POST;
        end
        ST_DIV: begin
          acc_r <= {div_rem, acc_r[62:0], 1'b0};
          opb_r <= {opb_r[62:0], div_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == cnt_last_r) state_r <= ST_POST;
        end
        ST_SQRT: begin
          acc_r <= {acc_r[125:0], 2'b00};
          opa_r <= {27'd0, sq_new};
          opb_r <= {31'd0, opb_r[31:0], sq_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == cnt_last_r) state_r <= ST_POST;
        end
        ST_POST: begin
          case (step_r)
            SP_SQX, SP_SQY, SP_SQZ: sum_r <= sum_add;
            SP_ROOT: begin
              root_r <= root;
              m_r <= m_val;
              s_neg_r <= s_neg;
              bad_r <= bad_val;
              fx_r <= '0;
              fy_r <= '0;
              fz_r <= '0;
            end
            SP_I2: i2_r <= mres;
            SP_I6: i6_r <= mres;
            SP_REP: fneg_r <= diff_neg ^ s_neg_r;
            SP_LJ: i2_r <= mres;
            SP_FP: fp_r <= dres;
            SP_FX: fx_r <= axis_force(mres, fneg_r, dx_r[32]);
            SP_FY: fy_r <= axis_force(mres, fneg_r, dy_r[32]);
            SP_FZ: fz_r <= axis_force(mres, fneg_r, dz_r[32]);
            default: ;
          endcase
        end
        ST_OUT: begin
          if (out_load) begin
            ogx_r <= fx_r;
            ogy_r <= fy_r;
            ogz_r <= fz_r;
            obad_r <= bad_r;
            oiv_r <= lastp_r;
            out_valid_r <= 1'b1;
            if (lastp_r) begin
              oix_r <= clamp48(ion_x_nxt);
              oiy_r <= clamp48(ion_y_nxt);
              oiz_r <= clamp48(ion_z_nxt);
              ion_x_r <= '0;
              ion_y_r <= '0;
              ion_z_r <= '0;
            end else begin
              oix_r <= '0;
              oiy_r <= '0;
              oiz_r <= '0;
              ion_x_r <= ion_x_nxt;
              ion_y_r <= ion_y_nxt;
              ion_z_r <= ion_z_nxt;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: ;
        default: state_r <= ST_IDLE;
      endcase

      // launch the next operation on the shared unit
      unique case (go)
        GO_MUL: begin
          acc_r <= '0;
          opa_r <= la;
          opb_r <= lb;
          cnt_r <= '0;
          cnt_last_r <= WORD_LAST;
          step_r <= go_step;
          state_r <= ST_MUL;
        end
        GO_DIV: begin
          acc_r <= {32'd0, la, 32'd0};
          opa_r <= lb;
          opb_r <= '0;
          div_sat_r <= {32'd0, la[63:32]} >= lb;
          cnt_r <= '0;
          cnt_last_r <= WORD_LAST;
          step_r <= go_step;
          state_r <= ST_DIV;
        end
        GO_SQRT: begin
          acc_r <= {62'd0, sum_add};
          opa_r <= '0;
          opb_r <= '0;
          cnt_r <= '0;
          cnt_last_r <= ROOT_LAST;
          step_r <= go_step;
          state_r <= ST_SQRT;
        end
        GO_OUT: state_r <= ST_OUT;
        GO_NONE: ;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_gas_force_x = ogx_r;
  assign out_gas_force_y = ogy_r;
  assign out_gas_force_z = ogz_r;
  assign out_ion_total_x = oix_r;
  assign out_ion_total_y = oiy_r;
  assign out_ion_total_z = oiz_r;
  assign out_ion_total_valid = oiv_r;
  assign out_bad_distance = obad_r;

`ifndef SYNTHESIS
  // an accepted pair always starts on the squaring step
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL && step_r == SP_SQX))
    else $error("accepted pair did not start squaring");

  // the bit counter never runs past the length of its operation
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL || state_r == ST_DIV || state_r == ST_SQRT) |-> cnt_r <= cnt_last_r)
    else $error("bit counter overran");

  // a zero distance beat carries no gas force
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_distance) |->
      (out_gas_force_x == 48'sd0 && out_gas_force_y == 48'sd0 && out_gas_force_z == 48'sd0))
    else $error("force on zero distance beat");

  // ion totals are zero unless flagged
  a_total_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ion_total_valid) |->
      (out_ion_total_x == 48'sd0 && out_ion_total_y == 48'sd0 && out_ion_total_z == 48'sd0))
    else $error("ion total on non-last beat");

  // a pending result is never overwritten by the next pair
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_gas_force_x)))
    else $error("pending beat overwritten");
`endif

endmodule

`default_nettype wire
